/* src/mhlr_pkg.sv */
package mhlr_pkg;

	// configuration port
	localparam int CfgAddrW = 8;
	localparam int CfgDataW = 8;

	localparam logic [CfgAddrW-1:0] REG_MESH_WIDTH   = 8'd0;
	localparam logic [CfgAddrW-1:0] REG_CORE_COUNT   = 8'd1;
	localparam logic [CfgAddrW-1:0] REG_HOP_LATENCY  = 8'd2;
	localparam logic [CfgAddrW-1:0] REG_STATS_ENABLE = 8'd3;

	// register reset values
	localparam logic [6:0] MeshWidthRst   = 7'd8;
	localparam logic [6:0] CoreCountRst   = 7'd64;
	localparam logic [7:0] HopLatencyRst  = 8'd1;
	localparam logic       StatsEnableRst = 1'b1;

	// parameter defaults
	localparam int MaxCoresDef   = 64;
	localparam int TotalWidthDef = 48;

	// stream widths
	localparam int STdataW = 80;
	localparam int MTdataW = 168;

	// upper bound on hop cost: 126 hops times the largest 8-bit hop latency
	localparam logic [14:0] HopCyclesMax = 15'd32130;

endpackage

/* src/mesh_hop_latency_router_core.sv */
// unicast: two divisions (source and receiver index), then a multiply and an
// accumulate step before the result beat; next input taken after the result beat
// broadcast: one division of the source index, then for each core a multiply, an
// accumulate and a result beat that waits on output stall; the shared 6-step restoring divider
// and the one-item sequencer do this work; input is not taken while an item is in work
// arst_n clears the registers to their reset values and the totals to zero
module mesh_hop_latency_router_core #(
	parameter int MAX_CORES   = mhlr_pkg::MaxCoresDef,
	parameter int TOTAL_WIDTH = mhlr_pkg::TotalWidthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input packet stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// sender[5:0], receiver[11:6], send_time[59:12], pkt_length[75:60]
	input  logic [mhlr_pkg::STdataW-1:0]  s_tdata,
	// is_broadcast[0]
	input  logic [0:0]                    s_tuser,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// dest[5:0], arrival_time[53:6], hop_cycles[68:54],
	// bytes_total[116:69], latency_total[164:117]
	output logic [mhlr_pkg::MTdataW-1:0]  m_tdata,
	output logic                          m_tlast,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mhlr_pkg::CfgAddrW-1:0] cfg_addr,
	input  logic [mhlr_pkg::CfgDataW-1:0] cfg_data
);

	localparam logic [6:0] MaxN = 7'(MAX_CORES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_SRC,
		ST_DIV_DST,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0] mesh_width_q;
	logic [6:0] core_count_q;
	logic [7:0] hop_latency_q;
	logic       stats_enable_q;

	// totals
	logic [TOTAL_WIDTH-1:0] bytes_acc_q;
	logic [TOTAL_WIDTH-1:0] latency_acc_q;

	// item in work
	logic [5:0]  rcv_q;
	logic        bcast_q;
	logic [47:0] send_time_q;
	logic [15:0] pkt_length_q;
	logic [6:0]  limit_q;
	logic [5:0]  bcast_index_q;
	logic [5:0]  src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [14:0] hop_cycles_q;

	// shared divider
	logic [5:0] dvd_q;
	logic [6:0] rem_q;
	logic [2:0] step_q;

	// output register
	logic [5:0]  out_dest_q;
	logic [47:0] out_arrival_q;
	logic [14:0] out_hop_q;
	logic        out_last_q;
	logic [47:0] out_bytes_q;
	logic [47:0] out_lat_q;

	// combinational signals
	logic [6:0]  w_eff;
	logic [6:0]  n_eff;
	logic [7:0]  rem_shift;
	logic        sub_ok;
	logic [6:0]  rem_new;
	logic [5:0]  dvd_new;
	logic [5:0]  col_diff, row_diff;
	logic [6:0]  hop_dist;
	logic [48:0] arrival_sum;
	logic [TOTAL_WIDTH:0] bytes_sum, lat_sum;
	logic [TOTAL_WIDTH-1:0] bytes_next, lat_next;
	logic        is_last;
	logic        col_wrap;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign cfg_ready = 1'b1;
	assign m_tlast   = out_last_q;
	assign m_tdata   = {3'd0, out_lat_q, out_bytes_q, out_hop_q, out_arrival_q, out_dest_q};

	// effective mesh width and broadcast count
	assign w_eff = (mesh_width_q == 7'd0) ? 7'd1 : mesh_width_q;
	assign n_eff = (core_count_q > MaxN) ? MaxN : core_count_q;

	// one restoring division step
	always_comb begin
		rem_shift = {rem_q, dvd_q[5]};
		sub_ok    = (rem_shift >= {1'b0, w_eff});
		rem_new   = sub_ok ? 7'(rem_shift - {1'b0, w_eff}) : rem_shift[6:0];
		dvd_new   = {dvd_q[4:0], sub_ok};
	end

	// manhattan distance
	always_comb begin
		col_diff = (src_col_q >= dst_col_q) ? src_col_q - dst_col_q : dst_col_q - src_col_q;
		row_diff = (src_row_q >= dst_row_q) ? src_row_q - dst_row_q : dst_row_q - src_row_q;
		hop_dist = {1'b0, col_diff} + {1'b0, row_diff};
	end

	// saturating sums, last-beat and column-wrap flags
	always_comb begin
		arrival_sum = {1'b0, send_time_q} + {34'd0, hop_cycles_q};
		bytes_sum   = {1'b0, bytes_acc_q} + (TOTAL_WIDTH + 1)'(pkt_length_q);
		lat_sum     = {1'b0, latency_acc_q} + (TOTAL_WIDTH + 1)'(hop_cycles_q);
		bytes_next  = bytes_sum[TOTAL_WIDTH] ? '1 : bytes_sum[TOTAL_WIDTH-1:0];
		lat_next    = lat_sum[TOTAL_WIDTH] ? '1 : lat_sum[TOTAL_WIDTH-1:0];
		is_last     = !bcast_q || (({1'b0, bcast_index_q} + 7'd1) == limit_q);
		col_wrap    = (({1'b0, dst_col_q} + 7'd1) == w_eff);
	end

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mesh_width_q   <= mhlr_pkg::MeshWidthRst;
			core_count_q   <= mhlr_pkg::CoreCountRst;
			hop_latency_q  <= mhlr_pkg::HopLatencyRst;
			stats_enable_q <= mhlr_pkg::StatsEnableRst;
			bytes_acc_q    <= '0;
			latency_acc_q  <= '0;
			bcast_index_q  <= '0;
			out_last_q     <= 1'b0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_addr)
					mhlr_pkg::REG_MESH_WIDTH:   mesh_width_q   <= cfg_data[6:0];
					mhlr_pkg::REG_CORE_COUNT:   core_count_q   <= cfg_data[6:0];
					mhlr_pkg::REG_HOP_LATENCY:  hop_latency_q  <= cfg_data[7:0];
					mhlr_pkg::REG_STATS_ENABLE: stats_enable_q <= cfg_data[0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						dvd_q         <= s_tdata[5:0];
						rcv_q         <= s_tdata[11:6];
						send_time_q   <= s_tdata[59:12];
						pkt_length_q  <= s_tdata[75:60];
						bcast_q       <= s_tuser[0];
						limit_q       <= n_eff;
						rem_q         <= '0;
						step_q        <= '0;
						bcast_index_q <= '0;
						dst_col_q     <= '0;
						dst_row_q     <= '0;
						// a broadcast to no core is dropped
						if (!(s_tuser[0] && n_eff == 7'd0))
							state_q <= ST_DIV_SRC;
					end
				end
				ST_DIV_SRC: begin
					rem_q  <= rem_new;
					dvd_q  <= dvd_new;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						src_col_q <= rem_new[5:0];
						src_row_q <= dvd_new;
						rem_q     <= '0;
						step_q    <= '0;
						dvd_q     <= rcv_q;
						state_q   <= bcast_q ? ST_MUL : ST_DIV_DST;
					end
				end
				ST_DIV_DST: begin
					rem_q  <= rem_new;
					dvd_q  <= dvd_new;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						dst_col_q <= rem_new[5:0];
						dst_row_q <= dvd_new;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					hop_cycles_q <= {8'd0, hop_dist} * {7'd0, hop_latency_q};
					state_q      <= ST_ACC;
				end
				ST_ACC: begin
					if (stats_enable_q) begin
						bytes_acc_q   <= bytes_next;
						latency_acc_q <= lat_next;
						out_bytes_q   <= 48'(64'(bytes_next));
						out_lat_q     <= 48'(64'(lat_next));
					end else begin
						out_bytes_q   <= 48'(64'(bytes_acc_q));
						out_lat_q     <= 48'(64'(latency_acc_q));
					end
					out_dest_q    <= bcast_q ? bcast_index_q : rcv_q;
					out_arrival_q <= arrival_sum[48] ? '1 : arrival_sum[47:0];
					out_hop_q     <= hop_cycles_q;
					out_last_q    <= is_last;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						if (out_last_q) begin
							bcast_index_q <= '0;
							state_q       <= ST_IDLE;
						end else begin
							// step to the next core on the mesh
							bcast_index_q <= bcast_index_q + 6'd1;
							if (col_wrap) begin
								dst_col_q <= '0;
								dst_row_q <= dst_row_q + 6'd1;
							end else begin
								dst_col_q <= dst_col_q + 6'd1;
							end
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/mhlr_checker.sv */
module mhlr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [0:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mhlr_pkg::MTdataW-1:0]  m_tdata,
	input logic                          m_tlast
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed under stall");

	// never taking input while a result is pending
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// a unicast beat always keeps the block busy
	a_unicast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> !s_tready)
		else $error("ready right after unicast beat");

	// after the last result beat the block is free again
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after last result");

	// hop cost never exceeds the mesh bound
	a_hop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[68:54] <= mhlr_pkg::HopCyclesMax)
		else $error("hop cycles out of range");

endmodule

bind mesh_hop_latency_router_core mhlr_checker u_mhlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);
